// ----- design/ws4ls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ws4ls_pkg: shared definitions of the four-lane LED line serialiser
// Lane count, field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ws4ls_pkg;

    localparam int LANES     = 4;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 10;
    localparam int COUNT_W   = 16;
    localparam int BITIDX_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_t;
    typedef logic [LANES-1:0]             lane_bits_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_T0H_CYCLES     = 3'd0,
        CFG_T1H_CYCLES     = 3'd1,
        CFG_BIT_CYCLES     = 3'd2,
        CFG_BYTES_PER_LANE = 3'd3,
        CFG_INVERT_OUTPUT  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_LOAD = 1'b1
    } req_type_t;

    localparam logic [TIME_W-1:0]  T0H_RESET        = 10'd64;
    localparam logic [TIME_W-1:0]  T1H_RESET        = 10'd160;
    localparam logic [TIME_W-1:0]  BIT_RESET        = 10'd224;
    localparam logic [COUNT_W-1:0] BYTES_RESET      = 16'd384;
    localparam logic               INVERT_RESET     = 1'b1;
    localparam logic [COUNT_W-1:0] GROUPS_SATURATED = 16'hFFFF;

endpackage
`default_nettype wire

// ----- design/ws2812_four_lane_serializer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_four_lane_serializer: four-lane one-wire LED line serialiser
// Turns tick and load items into pulse-width coded line levels for four
// LED strip lanes, with frame end, underrun and buffer status flags.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is captured in the input register, then its result is
// registered in the result register after one pass of the timing logic.
// Throughput: one item per cycle while m_axis_tready does not stall the output.
// Reset: rst_n clears all control state and loads the register defaults;
// the holding buffer is not cleared and is only read once written.
module ws2812_four_lane_serializer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // lane0_byte, lane1_byte, lane2_byte, lane3_byte
    input  wire logic        s_axis_tuser,   // req_type
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // line_levels, zero padding
    output      logic [3:0]  m_axis_tuser,   // load_accepted, want_data, underrun, frame_done
    input  wire logic                            cfg_we,
    input  wire logic [ws4ls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ws4ls_pkg::CFG_W-1:0]     cfg_data
);

    logic [ws4ls_pkg::TIME_W-1:0]  t0h_reg;
    logic [ws4ls_pkg::TIME_W-1:0]  t1h_reg;
    logic [ws4ls_pkg::TIME_W-1:0]  bit_cycles_reg;
    logic [ws4ls_pkg::COUNT_W-1:0] bytes_per_lane_reg;
    logic                          invert_reg;

    logic                          in_valid_reg;
    logic                          in_type_reg;
    ws4ls_pkg::lane_bytes_t        in_bytes_reg;

    logic [ws4ls_pkg::TIME_W-1:0]   tick_reg, tick_next;
    logic [ws4ls_pkg::BITIDX_W-1:0] bit_idx_reg, bit_idx_next;
    ws4ls_pkg::lane_bytes_t         shift_reg, shift_next;
    ws4ls_pkg::lane_bytes_t         hold_reg;
    logic                           hold_valid_reg, hold_valid_next;
    logic [ws4ls_pkg::COUNT_W-1:0]  groups_reg, groups_next;
    logic                           sending_reg, sending_next;
    ws4ls_pkg::lane_bits_t          levels_reg, levels_next;

    logic                           out_valid_reg;
    logic [7:0]                     out_data_reg;
    logic [3:0]                     out_user_reg;

    logic                           advance;
    logic                           load_write;
    logic                           accepted_next;
    logic                           under_next;
    logic                           done_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0h_reg            <= ws4ls_pkg::T0H_RESET;
            t1h_reg            <= ws4ls_pkg::T1H_RESET;
            bit_cycles_reg     <= ws4ls_pkg::BIT_RESET;
            bytes_per_lane_reg <= ws4ls_pkg::BYTES_RESET;
            invert_reg         <= ws4ls_pkg::INVERT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ws4ls_pkg::CFG_T0H_CYCLES:     t0h_reg <= cfg_data[ws4ls_pkg::TIME_W-1:0];
                ws4ls_pkg::CFG_T1H_CYCLES:     t1h_reg <= cfg_data[ws4ls_pkg::TIME_W-1:0];
                ws4ls_pkg::CFG_BIT_CYCLES:
                    bit_cycles_reg <= cfg_data[ws4ls_pkg::TIME_W-1:0];
                ws4ls_pkg::CFG_BYTES_PER_LANE: bytes_per_lane_reg <= cfg_data;
                ws4ls_pkg::CFG_INVERT_OUTPUT:  invert_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_type_reg  <= s_axis_tuser;
            in_bytes_reg <= s_axis_tdata;
        end
    end

    always_comb
    begin
        logic                           start;
        logic                           boundary;
        logic                           lane_bit;
        logic [ws4ls_pkg::TIME_W-1:0]   high_time;
        logic [ws4ls_pkg::TIME_W-1:0]   tick_cur;
        logic [ws4ls_pkg::TIME_W-1:0]   tick_inc;
        logic [ws4ls_pkg::BITIDX_W-1:0] bit_cur;
        logic [ws4ls_pkg::BITIDX_W-1:0] bit_inc;
        logic [ws4ls_pkg::COUNT_W-1:0]  groups_cur;

        tick_next       = tick_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        hold_valid_next = hold_valid_reg;
        groups_next     = groups_reg;
        sending_next    = sending_reg;
        levels_next     = levels_reg;
        load_write      = 1'b0;
        accepted_next   = 1'b0;
        under_next      = 1'b0;
        done_next       = 1'b0;

        start      = !sending_reg && hold_valid_reg;
        tick_cur   = start ? '0 : tick_reg;
        bit_cur    = start ? '0 : bit_idx_reg;
        groups_cur = start ? '0 : groups_reg;
        boundary   = (tick_cur == '0) && (bit_cur == '0);
        tick_inc   = tick_cur + 1'b1;
        bit_inc    = bit_cur + 1'b1;
        lane_bit   = 1'b0;
        high_time  = '0;

        if (in_type_reg == ws4ls_pkg::REQ_LOAD)
        begin
            if (!hold_valid_reg)
            begin
                load_write      = 1'b1;
                hold_valid_next = 1'b1;
                accepted_next   = 1'b1;
            end
        end
        else if (!(sending_reg || start))
        begin
            levels_next = '0;
        end
        else if (boundary && !hold_valid_reg)
        begin
            levels_next = '0;
            under_next  = 1'b1;
        end
        else
        begin
            sending_next = 1'b1;
            groups_next  = groups_cur;
            tick_next    = tick_cur;
            bit_idx_next = bit_cur;
            if (boundary)
            begin
                shift_next      = hold_reg;
                hold_valid_next = 1'b0;
                if (groups_cur != ws4ls_pkg::GROUPS_SATURATED)
                begin
                    groups_next = groups_cur + 1'b1;
                end
            end
            for (int i = 0; i < ws4ls_pkg::LANES; i++)
            begin
                lane_bit       = shift_next[i][3'd7 - bit_cur];
                high_time      = lane_bit ? t1h_reg : t0h_reg;
                levels_next[i] = tick_cur < high_time;
            end
            tick_next = tick_inc;
            if (tick_inc >= bit_cycles_reg)
            begin
                tick_next    = '0;
                bit_idx_next = bit_inc;
                if ((bit_inc == '0) && (groups_next >= bytes_per_lane_reg))
                begin
                    done_next    = 1'b1;
                    sending_next = 1'b0;
                    groups_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
            hold_valid_reg <= 1'b0;
            groups_reg     <= '0;
            sending_reg    <= 1'b0;
            levels_reg     <= '0;
        end
        else if (advance)
        begin
            tick_reg       <= tick_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
            hold_valid_reg <= hold_valid_next;
            groups_reg     <= groups_next;
            sending_reg    <= sending_next;
            levels_reg     <= levels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_write)
        begin
            hold_reg <= in_bytes_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {4'b0000, levels_next ^ {ws4ls_pkg::LANES{invert_reg}}};
            out_user_reg <= {done_next, under_next, !hold_valid_next, accepted_next};
        end
    end

    // An underrun always leaves the lines logically low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[2]) |-> (levels_reg == '0))
        else $error("underrun reported with lines not low");

    // Load results never carry tick-only flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_user_reg[0] && (out_user_reg[2] || out_user_reg[3])))
        else $error("load result carries underrun or frame end");

    // The end of a frame leaves the serialiser idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[3]) |-> !sending_reg)
        else $error("frame end reported while still sending");

    // The group count is cleared whenever no frame is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (groups_reg == '0))
        else $error("group count not cleared while idle");

endmodule
`default_nettype wire
